// ===== hdl/tsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsbp_pkg
// Shared types and constants for the six-bit text packer: the character and
// packed-byte words and the push bundle between the packer and its queue.
// ----------------------------------------------------------------------------
package tsbp_pkg;

	// default depth of the output queue, in words
	localparam int unsigned QueueDepth = 4;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       end_of_text;
	} char_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       last_byte;
	} pack_t;

	// up to two packed words produced by one character
	typedef struct packed {
		logic [1:0] count;
		pack_t      first;
		pack_t      second;
	} push_t;

endpackage

// ===== hdl/text_six_bit_packer.sv =====
// ----------------------------------------------------------------------------
// text_six_bit_packer
// Maps text bytes to six-bit codes and packs them LSB first into bytes.
// ----------------------------------------------------------------------------
// Usage:
// char channel (char_valid / char_stall / char_data) takes one text byte per
// word; end_of_text marks the final character of a string.
// pack channel (pack_valid / pack_stall / pack_data) gives packed bytes in
// order; last_byte marks the final byte of a string, zero padded on top.
// Four characters give three bytes; a string end may add one flush byte.
// Flow: a taken character is held in the input register; once the queue has
// room it is folded into the held bits and its bytes are written to the queue.
// Throughput: one character per cycle unless stalled; the output drains one
// byte per cycle unless stalled, from a queue of QueueDepth words, and
// char_stall rises only while that queue holds more than QueueDepth-2 words.
// When the receiver stalls, the shown word holds and the queue fills, then
// the input stalls with the held character kept in the input register.
// Reset empties the input register and the queue and clears the held bits,
// so the first character after reset starts a new string.
// ----------------------------------------------------------------------------
module text_six_bit_packer #(
	parameter int unsigned QueueDepth = tsbp_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	input  tsbp_pkg::char_t  char_data,
	output logic             pack_valid,
	input  logic             pack_stall,
	output tsbp_pkg::pack_t  pack_data
);

	tsbp_pkg::push_t push;
	logic            room;

	tsbp_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.room       (room),
		.push       (push)
	);

	tsbp_outq #(
		.Depth (QueueDepth)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.pack_valid (pack_valid),
		.pack_stall (pack_stall),
		.pack_data  (pack_data)
	);

endmodule

// ===== hdl/tsbp_pack.sv =====
// ----------------------------------------------------------------------------
// tsbp_pack
// Input register, character-to-code map and bit accumulator. Each registered
// character is folded into the held bits and yields zero, one or two bytes.
// ----------------------------------------------------------------------------
module tsbp_pack (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	input  tsbp_pkg::char_t  char_data,
	input  logic             room,
	output tsbp_pkg::push_t  push
);

	logic            valid_s1;
	tsbp_pkg::char_t data_s1;
	logic [5:0]      held_bits_q;
	logic [2:0]      held_count_q;

	logic            fire;
	logic [5:0]      code;
	logic [2:0]      cnt;
	logic [6:0]      one_sh;
	logic [5:0]      mask;
	logic [11:0]     acc;
	logic [3:0]      total;
	logic            full;
	logic [7:0]      rem;
	logic [3:0]      rtot;
	logic            flush;

	function automatic logic [5:0] code_for_char(input logic [7:0] c);
		logic [7:0] r;
		r = 8'd0;
		if (c >= 8'h61 && c <= 8'h7a) begin
			r = {3'd0, c[4:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {4'h2, c[3:0]};
		end else if (c >= 8'h21 && c <= 8'h23) begin
			r = ({6'd0, c[1:0]} | 8'h18) + 8'h02;
		end else if (c >= 8'h25 && c <= 8'h26) begin
			r = ({5'd0, c[2:0]} | 8'h18) + 8'h01;
		end else if (c >= 8'h27 && c <= 8'h2f) begin
			r = c + 8'h03;
		end else if (c >= 8'h3a && c <= 8'h3e) begin
			r = (c ^ 8'h08) + 8'h01;
		end else if (c == 8'h5b) begin
			r = 8'h38;
		end else if (c >= 8'h5d && c <= 8'h5f) begin
			r = c ^ 8'h64;
		end else if (c >= 8'h7b && c <= 8'h7e) begin
			r = {2'd0, c[5:0]} + 8'h01;
		end
		return r[5:0];
	endfunction

	assign char_stall = valid_s1 & ~room;
	assign fire       = valid_s1 & room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			data_s1 <= char_data;
		end
	end

	always_comb begin
		code   = code_for_char(data_s1.ascii_char);
		// held count is always even, stray low bit ignored
		cnt    = {held_count_q[2:1], 1'b0};
		one_sh = 7'd1 << cnt;
		mask   = 6'(one_sh - 7'd1);
		acc    = {6'd0, held_bits_q & mask} | ({6'd0, code} << cnt);
		total  = {1'b0, cnt} + 4'd6;
		full   = total >= 4'd8;
		rem    = full ? {4'd0, acc[11:8]} : acc[7:0];
		rtot   = full ? (total - 4'd8) : total;
		flush  = data_s1.end_of_text && (rtot != 4'd0);

		push = '0;
		if (full) begin
			push.first.packed_byte  = acc[7:0];
			push.first.last_byte    = data_s1.end_of_text && (rtot == 4'd0);
			push.second.packed_byte = rem;
			push.second.last_byte   = 1'b1;
			push.count              = flush ? 2'd2 : 2'd1;
		end else begin
			// leftover bits only, already zero above rtot
			push.first.packed_byte = rem;
			push.first.last_byte   = 1'b1;
			push.count             = flush ? 2'd1 : 2'd0;
		end
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bits_q  <= '0;
			held_count_q <= '0;
		end else if (fire) begin
			if (data_s1.end_of_text) begin
				held_bits_q  <= '0;
				held_count_q <= '0;
			end else begin
				held_bits_q  <= rem[5:0];
				held_count_q <= rtot[2:0];
			end
		end
	end

endmodule

// ===== hdl/tsbp_outq.sv =====
// ----------------------------------------------------------------------------
// tsbp_outq
// Small output queue for packed bytes. Takes up to two words per cycle from
// the packer and presents one word per cycle on the output unless stalled.
// ----------------------------------------------------------------------------
module tsbp_outq #(
	parameter int unsigned Depth = tsbp_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tsbp_pkg::push_t  push,
	output logic             room,
	output logic             pack_valid,
	input  logic             pack_stall,
	output tsbp_pkg::pack_t  pack_data
);

	localparam int unsigned PtrW = (Depth > 2) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

	tsbp_pkg::pack_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic [PtrW-1:0] wr1;
	logic [PtrW-1:0] wr2;
	logic            pop;

	function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
		return (p == LastIdx) ? '0 : p + PtrW'(1);
	endfunction

	assign wr1        = inc(wr_ptr_q);
	assign wr2        = inc(wr1);
	assign pack_valid = count_q != '0;
	assign pack_data  = mem_q[rd_ptr_q];
	assign pop        = pack_valid & ~pack_stall;
	// room for a worst-case pair of words
	assign room       = count_q <= RoomMax;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (push.count)
				2'd1:    wr_ptr_q <= wr1;
				2'd2:    wr_ptr_q <= wr2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

endmodule

// ===== hdl/tsbp_checker.sv =====
// ----------------------------------------------------------------------------
// tsbp_checker
// Port-level checks for the six-bit text packer, bound to the top level.
// ----------------------------------------------------------------------------
module tsbp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            char_valid,
	input logic            char_stall,
	input tsbp_pkg::char_t char_data,
	input logic            pack_valid,
	input logic            pack_stall,
	input tsbp_pkg::pack_t pack_data
);

	// a stalled output word stays put
	a_pack_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pack_valid && pack_stall |=> pack_valid && $stable(pack_data))
		else $error("packed word changed while stalled");

	// input stalls only while a character from an earlier word is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> $past(char_valid && !char_stall) || $past(char_stall))
		else $error("input stall with no held character");

	// input backs up only when output words are waiting
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> pack_valid)
		else $error("input stall with empty output queue");

endmodule

bind text_six_bit_packer tsbp_checker u_tsbp_checker (.*);

// ===== test/text_six_bit_packer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_six_bit_packer_test
// Feeds directed and random text strings into the six-bit packer, predicts the
// packed byte stream as each character is taken and checks every byte that
// comes out, under phases of no idling, sender gaps, receiver stalls and both.
// ----------------------------------------------------------------------------
module text_six_bit_packer_test;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	localparam int unsigned DirectedCount = 25;
	// string ends fall on characters 0, 2, 5, 9, 16 and 24
	localparam logic [DirectedCount-1:0] DirectedEnds = 25'h1010225;
	localparam logic [7:0] DirectedChars [DirectedCount] = '{
		8'h61,
		8'h7a, 8'h30,
		8'h39, 8'h21, 8'h23,
		8'h25, 8'h26, 8'h27, 8'h2f,
		8'h3a, 8'h3e, 8'h5b, 8'h5d, 8'h5f, 8'h7b, 8'h7e,
		8'h00, 8'hff, 8'h20, 8'h41, 8'h24, 8'h5c, 8'h60, 8'h7f
	};
	localparam int unsigned ReportCap = 200;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            char_valid = 1'b0;
	logic            char_stall;
	tsbp_pkg::char_t char_data = '0;
	logic            pack_valid;
	logic            pack_stall = 1'b0;
	tsbp_pkg::pack_t pack_data;

	tsbp_pkg::char_t text_queue[$];
	tsbp_pkg::pack_t pending_bytes[$];
	logic [5:0]      held_bits = '0;
	int unsigned     held_count = 0;
	bit              char_took = 1'b0;
	int unsigned     gap_pct = 0;
	int unsigned     stall_pct = 0;
	int unsigned     failures = 0;

	text_six_bit_packer dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data(char_data),
		.pack_valid(pack_valid),
		.pack_stall(pack_stall),
		.pack_data(pack_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// six-bit code of one text byte, zero for anything unmapped
	function automatic logic [5:0] six_bit_code(logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7a) return 6'(c - 8'h61 + 8'h01);
		if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'h20);
		if (c >= 8'h21 && c <= 8'h23) return 6'(c - 8'h21 + 8'h1b);
		if (c >= 8'h25 && c <= 8'h26) return 6'(c - 8'h25 + 8'h1e);
		if (c >= 8'h27 && c <= 8'h2f) return 6'(c - 8'h27 + 8'h2a);
		if (c >= 8'h3a && c <= 8'h3e) return 6'(c - 8'h3a + 8'h33);
		if (c == 8'h5b) return 6'h38;
		if (c >= 8'h5d && c <= 8'h5f) return 6'(c - 8'h5d + 8'h39);
		if (c >= 8'h7b && c <= 8'h7e) return 6'(c - 8'h7b + 8'h3c);
		return 6'h00;
	endfunction

	// fold one character into the held bits and queue the bytes it completes or flushes
	task automatic pack_text_char(tsbp_pkg::char_t ch);
		logic [13:0]     acc;
		int unsigned     total;
		tsbp_pkg::pack_t word;
		acc = {8'b0, held_bits} | (14'(six_bit_code(ch.ascii_char)) << held_count);
		total = held_count + 6;
		if (total >= 8) begin
			word.packed_byte = acc[7:0];
			word.last_byte = ch.end_of_text && total == 8;
			pending_bytes.push_back(word);
			acc = acc >> 8;
			total = total - 8;
		end
		if (ch.end_of_text) begin
			// leftover bits go out zero padded
			if (total != 0) begin
				word.packed_byte = acc[7:0];
				word.last_byte = 1'b1;
				pending_bytes.push_back(word);
			end
			held_bits = '0;
			held_count = 0;
		end else begin
			held_bits = acc[5:0];
			held_count = total;
		end
	endtask

	function automatic logic [7:0] text_char();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 2) return 8'($urandom_range(0, 255));
		if (pick < 5) return 8'($urandom_range(8'h61, 8'h7a));
		if (pick < 6) return 8'($urandom_range(8'h30, 8'h39));
		return 8'($urandom_range(8'h21, 8'h7e));
	endfunction

	task automatic queue_string(int unsigned len, bit noisy);
		tsbp_pkg::char_t ch;
		for (int unsigned i = 0; i < len; i++) begin
			ch.ascii_char = noisy ? 8'($urandom_range(0, 255)) : text_char();
			ch.end_of_text = (i == len - 1);
			text_queue.push_back(ch);
		end
	endtask

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		failures++;
		if (failures <= ReportCap)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
	endtask

	// set the idle pattern, queue about n characters as strings, wait until the driver has drawn them all
	task automatic run_phase(idle_mode_t mode, int unsigned n);
		int unsigned done;
		int unsigned pick;
		int unsigned len;
		@(posedge clk);
		unique case (mode)
			IDLE_SENDER: begin
				gap_pct = 86;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = 86;
			end
			IDLE_BOTH: begin
				gap_pct = 7;
				stall_pct = 7;
			end
			default: begin
				gap_pct = 0;
				stall_pct = 0;
			end
		endcase
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 19);
			len = (pick == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			queue_string(len, pick == 1 || pick == 2);
			done += len;
		end
		while (text_queue.size() != 0) @(posedge clk);
	endtask

	// driver: a word stays up until taken, gaps and stalls drawn per cycle
	always @(negedge clk) begin
		if (!char_valid || char_took) begin
			if (text_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				char_valid <= 1'b1;
				char_data <= text_queue.pop_front();
			end else begin
				char_valid <= 1'b0;
			end
		end
		pack_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// monitor: check outgoing bytes, then predict from the character taken
	always @(posedge clk) begin
		tsbp_pkg::pack_t want;
		if (!arst_n) begin
			char_took = 1'b0;
		end else begin
			if (pack_valid && !pack_stall) begin
				if (pending_bytes.size() == 0) begin
					failures++;
					if (failures <= ReportCap)
						$display("%0t: unexpected byte, expected none, actual %0h/%0b",
							$time, pack_data.packed_byte, pack_data.last_byte);
				end else begin
					want = pending_bytes.pop_front();
					if (pack_data.packed_byte !== want.packed_byte)
						report_mismatch("packed_byte", want.packed_byte, pack_data.packed_byte);
					if (pack_data.last_byte !== want.last_byte)
						report_mismatch("last_byte", want.last_byte, pack_data.last_byte);
				end
			end
			char_took = char_valid && !char_stall;
			if (char_took) pack_text_char(char_data);
		end
	end

	initial begin
		tsbp_pkg::char_t ch;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		for (int unsigned i = 0; i < DirectedCount; i++) begin
			ch.ascii_char = DirectedChars[i];
			ch.end_of_text = DirectedEnds[i];
			text_queue.push_back(ch);
		end
		run_phase(IDLE_NONE, 300);
		run_phase(IDLE_SENDER, 400);
		run_phase(IDLE_RECEIVER, 400);
		run_phase(IDLE_BOTH, 450);
		run_phase(IDLE_NONE, 300);
		while (char_valid || pending_bytes.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
